>>> hw/rtl/sfod_pkg.sv
// Shared types and constants of the spectral flux onset detector.
// Holds the request payload structs and the fixed-point constants.
// No dependencies; sfod_isqrt, sfod_frame and the top level import it.
`default_nettype none

package sfod_pkg;

  // Field and datapath widths
  localparam int BIN_W      = 11;
  localparam int IN_W       = 24;
  localparam int SQ_W       = 47;
  localparam int RAD_W      = 52;
  localparam int MAG_W      = 26;
  localparam int ROOT_STEPS = 26;
  localparam int FLUX_W     = 37;
  localparam int LEVEL_W    = 48;
  localparam int SHIFT_W    = 4;
  localparam int COEF_W     = 16;
  localparam int FS_W       = 4;

  // Saturation limits
  localparam logic [FLUX_W-1:0]  FLUX_MAX  = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // Normalization shift: reset value and the shift that leaves flux unscaled
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_UNITY = 4'd14;

  // One-pole coefficients in Q16 and their complements
  localparam logic [COEF_W-1:0] FAST_COEF = 16'd39322;
  localparam logic [COEF_W-1:0] FAST_KEEP = 16'd26214;
  localparam logic [COEF_W-1:0] SLOW_COEF = 16'd2621;
  localparam logic [COEF_W-1:0] SLOW_KEEP = 16'd62915;
  localparam logic [32:0]       ROUND_HALF = 33'd32768;

  // Onset test: 5*fast > 9*slow + bias
  localparam logic [LEVEL_W+4:0] BIAS_X5 = (LEVEL_W + 5)'(1310);
  localparam logic [FS_W-1:0]    MIN_GAP = 4'd3;
  localparam logic [FS_W-1:0]    FS_SAT  = 4'd15;

  typedef struct packed {
    logic [BIN_W-1:0]       bin_index;
    logic signed [IN_W-1:0] left_re;
    logic signed [IN_W-1:0] left_im;
    logic signed [IN_W-1:0] right_re;
    logic signed [IN_W-1:0] right_im;
    logic                   last_bin;
  } sfod_in_t;

  typedef struct packed {
    logic               onset;
    logic [LEVEL_W-1:0] flux_level;
    logic [LEVEL_W-1:0] fast_level;
    logic [LEVEL_W-1:0] slow_level;
  } sfod_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfod_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on sfod_pkg for the radicand and root widths.
`default_nettype none

module sfod_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sfod_pkg::RAD_W-1:0] radicand,
  output logic                      done,
  output logic [sfod_pkg::MAG_W-1:0] root
);
  import sfod_pkg::*;

  localparam int CNT_W = $clog2(ROOT_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_STEPS - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0] rad_r;
  logic [MAG_W+1:0] rem_r;
  logic [MAG_W-1:0] root_r;

  logic [MAG_W+3:0] rem_sh;
  logic [MAG_W+3:0] trial;
  logic [MAG_W+3:0] diff;
  logic             take;
  logic [MAG_W+1:0] rem_nxt;
  logic [MAG_W-1:0] root_nxt;

  // One restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = rem_sh - trial;
    take     = rem_sh >= trial;
    rem_nxt  = take ? diff[MAG_W+1:0] : rem_sh[MAG_W+1:0];
    root_nxt = {root_r[MAG_W-2:0], take};
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Flag completion on the last step
      done_r <= !start && busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

>>> hw/rtl/sfod_mag_ram.sv
// Previous-magnitude store: one write port, one registered read port.
// No package dependency; depth and width come from the instance.
`default_nettype none

module sfod_mag_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 26
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/sfod_frame.sv
// End-of-frame unit: flux normalization, fast and slow envelopes, onset
// test and the result register. Depends on sfod_pkg.
`default_nettype none

module sfod_frame (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sfod_pkg::FLUX_W-1:0]  flux,
  input  logic [sfod_pkg::SHIFT_W-1:0] size_shift,
  output logic                         idle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sfod_pkg::sfod_out_t          out_data
);
  import sfod_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE, F_SHIFT, F_MUL, F_SUM, F_SCALE, F_OUT
  } frame_state_t;

  localparam int WIDE_W = FLUX_W + 14;
  localparam int A5_W   = LEVEL_W + 3;
  localparam int B9_W   = LEVEL_W + 5;
  localparam logic [3:0] MUL_LAST = 4'd8;

  // Accumulator tags: envelope and high or low half
  localparam logic [1:0] TAG_FAST_HI = 2'b00;
  localparam logic [1:0] TAG_FAST_LO = 2'b01;
  localparam logic [1:0] TAG_SLOW_HI = 2'b10;
  localparam logic [1:0] TAG_SLOW_LO = 2'b11;

  frame_state_t       state_r;
  logic [3:0]         step_r;
  logic [FLUX_W-1:0]  flux_r;
  logic [LEVEL_W-1:0] f_r;
  logic [LEVEL_W-1:0] prod_r;
  logic [1:0]         tag_r;
  logic               prod_vld_r;
  logic [LEVEL_W-1:0] fast_hi_r;
  logic [LEVEL_W-1:0] slow_hi_r;
  logic [32:0]        fast_lo_r;
  logic [32:0]        slow_lo_r;
  logic [LEVEL_W-1:0] fast_env_r;
  logic [LEVEL_W-1:0] slow_env_r;
  logic [FS_W-1:0]    fs_r;
  logic [FS_W-1:0]    fs_inc_r;
  logic [A5_W-1:0]    a5_r;
  logic [B9_W-1:0]    b9_r;
  logic               out_valid_r;
  sfod_out_t          out_r;

  logic [WIDE_W-1:0]  wide;
  logic [LEVEL_W-1:0] f_nxt;
  logic [LEVEL_W-1:0] src;
  logic [31:0]        mul_a;
  logic [COEF_W-1:0]  coef;
  logic [LEVEL_W-1:0] mul_p;
  logic               onset;
  logic               out_load;

  // Scale the flux by 2^(14-size_shift), saturating
  always_comb begin
    wide = WIDE_W'(flux_r) << (SHIFT_UNITY - size_shift);
    if (size_shift <= SHIFT_UNITY) begin
      f_nxt = (|wide[WIDE_W-1:LEVEL_W]) ? LEVEL_MAX : wide[LEVEL_W-1:0];
    end else begin
      f_nxt = LEVEL_W'(flux_r >> (size_shift - SHIFT_UNITY));
    end
  end

  // Select one partial product of the blend for this step
  always_comb begin
    src   = step_r[0] ? (step_r[2] ? slow_env_r : fast_env_r) : f_r;
    mul_a = step_r[1] ? {16'b0, src[15:0]} : src[LEVEL_W-1:16];
    if (step_r[0]) begin
      coef = step_r[2] ? SLOW_KEEP : FAST_KEEP;
    end else begin
      coef = step_r[2] ? SLOW_COEF : FAST_COEF;
    end
    mul_p = LEVEL_W'(mul_a) * LEVEL_W'(coef);
  end

  assign onset = (fs_inc_r > MIN_GAP) && ({2'b00, a5_r} > b9_r);

  // Load the result register when it is empty or being drained
  assign out_load = (state_r == F_OUT) && (!out_valid_r || out_ready);

  // Frame sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      step_r      <= '0;
      prod_vld_r  <= 1'b0;
      fast_env_r  <= '0;
      slow_env_r  <= '0;
      fs_r        <= FS_SAT;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a load, drop it once the request is taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        F_IDLE: begin
          if (start) begin
            flux_r  <= flux;
            state_r <= F_SHIFT;
          end
        end
        F_SHIFT: begin
          f_r        <= f_nxt;
          fast_hi_r  <= '0;
          slow_hi_r  <= '0;
          fast_lo_r  <= ROUND_HALF;
          slow_lo_r  <= ROUND_HALF;
          step_r     <= '0;
          prod_vld_r <= 1'b0;
          state_r    <= F_MUL;
        end
        F_MUL: begin
          // Issue a product, add the previous one
          prod_r     <= mul_p;
          tag_r      <= step_r[2:1];
          prod_vld_r <= step_r != MUL_LAST;
          step_r     <= step_r + 1'b1;
          if (prod_vld_r) begin
            case (tag_r)
              TAG_FAST_HI: fast_hi_r <= fast_hi_r + prod_r;
              TAG_FAST_LO: fast_lo_r <= fast_lo_r + 33'(prod_r[31:0]);
              TAG_SLOW_HI: slow_hi_r <= slow_hi_r + prod_r;
              TAG_SLOW_LO: slow_lo_r <= slow_lo_r + 33'(prod_r[31:0]);
              default: ;
            endcase
          end
          if (step_r == MUL_LAST) begin
            state_r <= F_SUM;
          end
        end
        F_SUM: begin
          fast_env_r <= fast_hi_r + LEVEL_W'(fast_lo_r >> 16);
          slow_env_r <= slow_hi_r + LEVEL_W'(slow_lo_r >> 16);
          state_r    <= F_SCALE;
        end
        F_SCALE: begin
          a5_r     <= (A5_W'(fast_env_r) << 2) + A5_W'(fast_env_r);
          b9_r     <= (B9_W'(slow_env_r) << 3) + B9_W'(slow_env_r) + BIAS_X5;
          fs_inc_r <= (fs_r == FS_SAT) ? FS_SAT : fs_r + 1'b1;
          state_r  <= F_OUT;
        end
        F_OUT: begin
          // Hold until the result register is free
          if (out_load) begin
            out_r.onset      <= onset;
            out_r.flux_level <= f_r;
            out_r.fast_level <= fast_env_r;
            out_r.slow_level <= slow_env_r;
            fs_r             <= onset ? '0 : fs_inc_r;
            state_r          <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign idle      = state_r == F_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> hw/rtl/spectral_flux_onset_detector_core.sv
// Spectral flux onset detector, top level; uses sfod_pkg, sfod_isqrt,
// sfod_mag_ram and sfod_frame. A bin in range goes through the 26-step
// square-root iteration; zero or out-of-range bins skip it. The last bin
// also passes the frame unit (eight products through one 32x16
// multiplier) before its request shows at the output.
// After reset all MAX_BINS entries of the magnitude store are cleared.
`default_nettype none

module spectral_flux_onset_detector_core #(
  parameter int MAX_BINS = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sfod_pkg::sfod_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sfod_pkg::sfod_out_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sfod_pkg::SHIFT_W-1:0] cfg_data
);
  import sfod_pkg::*;

  localparam int AW     = $clog2(MAX_BINS);
  localparam int BIN_XW = (AW > BIN_W) ? AW : BIN_W;
  localparam logic [BIN_XW:0] BIN_LIMIT = (BIN_XW + 1)'(MAX_BINS);
  localparam logic [AW-1:0]   CLR_LAST  = AW'(MAX_BINS - 1);

  // Square steps: one operand squared per step, the last step only adds
  localparam logic [2:0] SQ_LEFT_END = 3'd2;
  localparam logic [2:0] SQ_LAST     = 3'd4;
  localparam logic [1:0] OP_LEFT_RE  = 2'd0;
  localparam logic [1:0] OP_LEFT_IM  = 2'd1;
  localparam logic [1:0] OP_RIGHT_RE = 2'd2;
  localparam logic [1:0] OP_RIGHT_IM = 2'd3;

  typedef enum logic [2:0] {
    T_CLEAR, T_IDLE, T_SQ, T_ROOT, T_FLUX, T_FRAME
  } top_state_t;

  top_state_t          state_r;
  logic [AW-1:0]       clr_cnt_r;
  sfod_in_t            item_r;
  logic [AW-1:0]       addr_r;
  logic [2:0]          sq_step_r;
  logic [SQ_W-1:0]     sq_r;
  logic [SQ_W:0]       sum_l_r;
  logic [SQ_W:0]       sum_r_r;
  logic                root_start_r;
  logic [FLUX_W-1:0]   flux_sum_r;
  logic [SHIFT_W-1:0]  size_shift_r;

  logic                accept;
  logic [BIN_XW-1:0]   bin_x;
  logic                bin_ok_in;
  logic signed [IN_W-1:0]   sq_op;
  logic signed [2*IN_W-1:0] sq_full;
  logic                root_l_done;
  logic                root_r_done;
  logic [MAG_W-1:0]    root_left;
  logic [MAG_W-1:0]    root_right;
  logic [MAG_W:0]      mag_sum;
  logic [MAG_W-1:0]    mag_new;
  logic [MAG_W-1:0]    mag_prev;
  logic [MAG_W-1:0]    rise;
  logic [FLUX_W:0]     flux_add;
  logic [FLUX_W-1:0]   flux_nxt;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MAG_W-1:0]    ram_wdata;
  logic                frame_start;
  logic                frame_idle;

  // Accept a request only when idle and the frame unit is free
  assign in_ready  = (state_r == T_IDLE) && frame_idle;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Bin range check
  assign bin_x     = BIN_XW'(in_data.bin_index);
  assign bin_ok_in = (bin_x != '0) && ({1'b0, bin_x} < BIN_LIMIT);

  // Square one operand per step
  always_comb begin
    case (sq_step_r[1:0])
      OP_LEFT_RE:  sq_op = item_r.left_re;
      OP_LEFT_IM:  sq_op = item_r.left_im;
      OP_RIGHT_RE: sq_op = item_r.right_re;
      OP_RIGHT_IM: sq_op = item_r.right_im;
      default:     sq_op = item_r.left_re;
    endcase
    sq_full = sq_op * sq_op;
  end

  // Average magnitude, positive rise and saturating flux sum
  always_comb begin
    mag_sum  = {1'b0, root_left} + {1'b0, root_right};
    mag_new  = mag_sum[MAG_W:1];
    rise     = (mag_new > mag_prev) ? mag_new - mag_prev : '0;
    flux_add = {1'b0, flux_sum_r} + (FLUX_W + 1)'(rise);
    flux_nxt = flux_add[FLUX_W] ? FLUX_MAX : flux_add[FLUX_W-1:0];
  end

  // Store writes: clearing pass, then write-back of the new magnitude
  assign ram_we      = (state_r == T_CLEAR) || (state_r == T_FLUX);
  assign ram_waddr   = (state_r == T_CLEAR) ? clr_cnt_r : addr_r;
  assign ram_wdata   = (state_r == T_CLEAR) ? '0 : mag_new;
  assign frame_start = state_r == T_FRAME;

  // Main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_CLEAR;
      clr_cnt_r    <= '0;
      sq_step_r    <= '0;
      root_start_r <= 1'b0;
      flux_sum_r   <= '0;
      size_shift_r <= SHIFT_RESET;
    end else begin
      // Start both roots once the last square is added
      root_start_r <= (state_r == T_SQ) && (sq_step_r == SQ_LAST);
      if (cfg_valid) begin
        size_shift_r <= cfg_data;
      end
      case (state_r)
        T_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CLR_LAST) begin
            state_r <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (accept) begin
            item_r    <= in_data;
            addr_r    <= bin_x[AW-1:0];
            sum_l_r   <= '0;
            sum_r_r   <= '0;
            sq_step_r <= '0;
            if (bin_ok_in) begin
              state_r <= T_SQ;
            end else if (in_data.last_bin) begin
              state_r <= T_FRAME;
            end
          end
        end
        T_SQ: begin
          sq_r      <= sq_full[SQ_W-1:0];
          sq_step_r <= sq_step_r + 1'b1;
          if (sq_step_r != '0) begin
            if (sq_step_r <= SQ_LEFT_END) begin
              sum_l_r <= sum_l_r + (SQ_W + 1)'(sq_r);
            end else begin
              sum_r_r <= sum_r_r + (SQ_W + 1)'(sq_r);
            end
          end
          if (sq_step_r == SQ_LAST) begin
            state_r <= T_ROOT;
          end
        end
        T_ROOT: begin
          if (root_l_done) begin
            state_r <= T_FLUX;
          end
        end
        T_FLUX: begin
          flux_sum_r <= flux_nxt;
          state_r    <= item_r.last_bin ? T_FRAME : T_IDLE;
        end
        T_FRAME: begin
          // Hand the frame flux over and restart the sum
          flux_sum_r <= '0;
          state_r    <= T_IDLE;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  sfod_isqrt u_root_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start_r),
    .radicand ({sum_l_r, 4'b0000}),
    .done     (root_l_done),
    .root     (root_left)
  );

  sfod_isqrt u_root_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start_r),
    .radicand ({sum_r_r, 4'b0000}),
    .done     (root_r_done),
    .root     (root_right)
  );

  sfod_mag_ram #(
    .DEPTH (MAX_BINS),
    .AW    (AW),
    .DW    (MAG_W)
  ) u_mag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (bin_x[AW-1:0]),
    .rdata (mag_prev)
  );

  sfod_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (frame_start),
    .flux       (flux_sum_r),
    .size_shift (size_shift_r),
    .idle       (frame_idle),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // A request that does work blocks the next one
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (bin_ok_in || in_data.last_bin) |=> !in_ready)
    else $error("input accepted again while a bin is in progress");

  // Both root units run in lockstep
  a_roots_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    root_l_done == root_r_done)
    else $error("square-root units out of step");

  // A root finishes only while the sequencer waits for it
  a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_l_done |-> state_r == T_ROOT)
    else $error("square root finished outside the wait state");

  // The frame unit is never restarted while busy
  a_frame_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    frame_start |-> frame_idle)
    else $error("frame started while the frame unit is busy");

endmodule

`default_nettype wire
